// ===== hw/rtl/sutf8v_pkg.sv =====
// Shared types and constants for the strict UTF-8 validator.
// No dependencies; every other file in hw/rtl imports this package.
`timescale 1ns / 1ps

package sutf8v_pkg;

  // Default queue depths (power of two, at least 2)
  localparam int SUTF8V_CLS_DEPTH = 2;
  localparam int SUTF8V_RES_DEPTH = 2;

  // Byte boundaries used by the checks
  localparam logic [7:0] BYTE_ZERO     = 8'h00;
  localparam logic [7:0] BYTE_ASCII_HI = 8'h80;
  localparam logic [7:0] LEAD2_LO      = 8'hc2;
  localparam logic [7:0] LEAD2_HI      = 8'hdf;
  localparam logic [7:0] LEAD3_LO      = 8'he0;
  localparam logic [7:0] LEAD3_HI      = 8'hef;
  localparam logic [7:0] LEAD4_LO      = 8'hf0;
  localparam logic [7:0] LEAD4_HI      = 8'hf4;
  localparam logic [7:0] LEAD_SURR     = 8'hed;
  localparam logic [7:0] CONT_LO       = 8'h80;
  localparam logic [7:0] CONT_HI       = 8'hbf;
  localparam logic [7:0] CONT_A0       = 8'ha0;
  localparam logic [7:0] CONT_90       = 8'h90;

  // Extra rule on the first continuation byte
  typedef enum logic [2:0] {
    RULE_NONE  = 3'd0,
    RULE_GE_A0 = 3'd1,
    RULE_LT_A0 = 3'd2,
    RULE_GE_90 = 3'd3,
    RULE_LT_90 = 3'd4
  } rule_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic ok_so_far;
    logic verdict_ready;
  } out_item_t;

  // Byte classified both as a lead byte and as a continuation byte
  typedef struct packed {
    logic       lead_bad;
    logic [1:0] lead_len;
    rule_t      lead_rule;
    logic       is_cont;
    logic       ge_a0;
    logic       ge_90;
    logic       final_byte;
  } cls_t;

endpackage

// ===== hw/rtl/sutf8v_classify.sv =====
// Front end classifier: decodes one raw byte into lead and continuation views.
// Depends on sutf8v_pkg.
`timescale 1ns / 1ps

module sutf8v_classify (
  input  sutf8v_pkg::in_item_t item_i,
  output sutf8v_pkg::cls_t     cls_o
);
  import sutf8v_pkg::*;

  logic [7:0] b;

  assign b = item_i.data_byte;

  always_comb begin
    cls_o            = '0;
    cls_o.final_byte = item_i.final_byte;
    cls_o.is_cont    = (b >= CONT_LO) && (b <= CONT_HI);
    cls_o.ge_a0      = (b >= CONT_A0);
    cls_o.ge_90      = (b >= CONT_90);
    cls_o.lead_rule  = RULE_NONE;
    cls_o.lead_len   = 2'd0;
    cls_o.lead_bad   = 1'b0;
    if (b == BYTE_ZERO) begin
      cls_o.lead_bad = 1'b1;
    end else if (b < BYTE_ASCII_HI) begin
      cls_o.lead_len = 2'd0;
    end else if ((b >= LEAD2_LO) && (b <= LEAD2_HI)) begin
      cls_o.lead_len = 2'd1;
    end else if ((b >= LEAD3_LO) && (b <= LEAD3_HI)) begin
      cls_o.lead_len = 2'd2;
    end else if ((b >= LEAD4_LO) && (b <= LEAD4_HI)) begin
      cls_o.lead_len = 2'd3;
    end else begin
      cls_o.lead_bad = 1'b1;
    end
    // tighter range on the byte after the edge-case leads
    if (b == LEAD3_LO) begin
      cls_o.lead_rule = RULE_GE_A0;
    end else if (b == LEAD_SURR) begin
      cls_o.lead_rule = RULE_LT_A0;
    end else if (b == LEAD4_LO) begin
      cls_o.lead_rule = RULE_GE_90;
    end else if (b == LEAD4_HI) begin
      cls_o.lead_rule = RULE_LT_90;
    end
  end

endmodule

// ===== hw/rtl/sutf8v_fifo.sv =====
// Small register queue with push/full and pop/empty sides.
// Depends on sutf8v_pkg for the default depth.
`timescale 1ns / 1ps

module sutf8v_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = sutf8v_pkg::SUTF8V_CLS_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);
  import sutf8v_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/sutf8v_check.sv =====
// Back end: runs the sequence state on classified bytes and forms one result each.
// Depends on sutf8v_pkg.
`timescale 1ns / 1ps

module sutf8v_check (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sutf8v_pkg::cls_t      cls_i,
  input  logic                  cls_valid_i,
  output logic                  cls_pop_o,
  input  logic                  res_full_i,
  output logic                  res_push_o,
  output sutf8v_pkg::out_item_t res_o
);
  import sutf8v_pkg::*;

  logic [1:0] pending_r, pending_nxt;
  rule_t      rule_r, rule_nxt;
  logic       failed_r, failed_nxt;
  logic       good;
  logic       step;
  logic       rule_ok;

  assign step       = cls_valid_i && !res_full_i;
  assign cls_pop_o  = step;
  assign res_push_o = step;

  always_comb begin
    case (rule_r)
      RULE_GE_A0: rule_ok = cls_i.ge_a0;
      RULE_LT_A0: rule_ok = !cls_i.ge_a0;
      RULE_GE_90: rule_ok = cls_i.ge_90;
      RULE_LT_90: rule_ok = !cls_i.ge_90;
      default:    rule_ok = 1'b1;
    endcase
  end

  always_comb begin
    pending_nxt = pending_r;
    rule_nxt    = rule_r;
    failed_nxt  = failed_r;
    good        = 1'b1;
    if (!failed_r) begin
      if (pending_r != 2'd0) begin
        good        = cls_i.is_cont && rule_ok;
        rule_nxt    = RULE_NONE;
        pending_nxt = pending_r - 2'd1;
      end else begin
        good        = !cls_i.lead_bad;
        pending_nxt = cls_i.lead_len;
        rule_nxt    = cls_i.lead_rule;
      end
      if (!good) begin
        failed_nxt  = 1'b1;
        pending_nxt = 2'd0;
        rule_nxt    = RULE_NONE;
      end
    end
    res_o.ok_so_far     = !failed_nxt && !(cls_i.final_byte && (pending_nxt != 2'd0));
    res_o.verdict_ready = cls_i.final_byte;
    // clear everything once the text closes
    if (cls_i.final_byte) begin
      pending_nxt = 2'd0;
      rule_nxt    = RULE_NONE;
      failed_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 2'd0;
      rule_r    <= RULE_NONE;
      failed_r  <= 1'b0;
    end else if (step) begin
      pending_r <= pending_nxt;
      rule_r    <= rule_nxt;
      failed_r  <= failed_nxt;
    end
  end

  a_failed_clears_seq: assert property (@(posedge clk) disable iff (!rst_n)
    failed_r |-> (pending_r == 2'd0) && (rule_r == RULE_NONE))
    else $error("failed state still holds an open sequence");

  a_rule_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (rule_r != RULE_NONE) |-> (pending_r != 2'd0))
    else $error("second-byte rule armed with no sequence open");

  a_final_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (step && cls_i.final_byte) |=> (pending_r == 2'd0) && !failed_r)
    else $error("state not cleared after final byte");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    res_push_o |-> !res_full_i)
    else $error("result pushed into full queue");

endmodule

// ===== hw/rtl/strict_utf8_validator_top.sv =====
// Top level of the strict UTF-8 validator: classifier, queue, checker, result queue.
// Depends on sutf8v_pkg, sutf8v_classify, sutf8v_fifo and sutf8v_check.
`timescale 1ns / 1ps
// A byte accepted into the classified-byte queue reaches the out_ ports once
// the checker moves it into the result queue; the checker stalls while that is full.
// Throughput: one byte per cycle sustained while the result queue has room; the
// checker's single state update per cycle sets that figure. Reset (rst_n low,
// synchronous) empties both queues and clears the sequence state; no clearing
// pass is needed.

module strict_utf8_validator_top #(
  parameter int CLS_DEPTH = sutf8v_pkg::SUTF8V_CLS_DEPTH,
  parameter int RES_DEPTH = sutf8v_pkg::SUTF8V_RES_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  sutf8v_pkg::in_item_t  in_data,
  output logic                  in_full,
  input  logic                  out_pop,
  output sutf8v_pkg::out_item_t out_data,
  output logic                  out_empty
);
  import sutf8v_pkg::*;

  cls_t      cls_front;   // classified byte entering the queue
  cls_t      cls_back;    // oldest classified byte, seen by the checker
  logic      cls_empty;
  logic      cls_pop;
  logic      res_full;
  logic      res_push;
  out_item_t res_item;

  // Front: classify the raw byte on the way in; no state involved
  sutf8v_classify u_classify (
    .item_i (in_data),
    .cls_o  (cls_front)
  );

  // Hold classified items so the front keeps taking bytes while the checker stalls
  sutf8v_fifo #(
    .W     ($bits(cls_t)),
    .DEPTH (CLS_DEPTH)
  ) u_cls_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .push_data (cls_front),
    .full      (in_full),
    .pop       (cls_pop),
    .pop_data  (cls_back),
    .empty     (cls_empty)
  );

  // Back: advance the sequence state one item per cycle when the result queue has room
  sutf8v_check u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .cls_i       (cls_back),
    .cls_valid_i (!cls_empty),
    .cls_pop_o   (cls_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_item)
  );

  // Result queue: the oldest result stays on out_data until popped
  sutf8v_fifo #(
    .W     ($bits(out_item_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_item),
    .full      (res_full),
    .pop       (out_pop),
    .pop_data  (out_data),
    .empty     (out_empty)
  );

endmodule
